FILE: hdl/pidff_pkg.sv
// ---------------------------------------------------------------------------
// PID feedforward package
// Shared constants: widths, register indexes, action codes, register reset
// values, saturation bounds and the default fixed-point format.
// ---------------------------------------------------------------------------
package pidff_pkg;

    // Default number of fraction bits of the signed fixed-point format.
    localparam int FRAC_BITS_DEF = 16;

    // Data and register width.
    localparam int DATA_W = 32;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd5;

    // Input action codes.
    localparam logic ACT_STEP  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // Register reset values (plus and minus one in Q16.16).
    localparam logic signed [DATA_W-1:0] OUT_MIN_RST = -32'sd65536;
    localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 32'sd65536;

    // Saturation bounds.
    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh80000000;

endpackage

FILE: hdl/pid_feedforward_antiwindup.sv
// ---------------------------------------------------------------------------
// PID controller with feedforward and anti-windup
// Fixed-point PID step built around one shared multiplier, one shared
// saturating adder and a bit-serial divider for the derivative term.
// ---------------------------------------------------------------------------
// Sequence: error, delta, integral term and candidate, feedforward and P
// terms and two sums; with the derivative on, the restoring divider then
// divides the D term by dt to 32 + FRAC_BITS quotient bits (48 at Q16.16),
// one quotient bit per cycle. Throughput: one item at a time; s_tready is
// high only while idle, and a clear item gives no result.
// Reset: rst_n clears the registers to their defaults, the integral and the
// last sample to zero; no clearing pass is needed.
module pid_feedforward_antiwindup #(
    parameter int FRAC_BITS = pidff_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // Configuration write port.
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    // Input items.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // target [31:0], sample [63:32], dt [95:64]
    input  logic         s_tuser,   // action [0]
    // Result items.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // drive [31:0]
    output logic         m_tuser    // limited [0]
);

    localparam int DW = 32 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    // Saturation bounds at product width.
    localparam logic signed [65:0] SAT_MAX_L = 66'sh7fffffff;
    localparam logic signed [65:0] SAT_MIN_L = -66'sh80000000;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ERR  = 4'd1;
    localparam logic [3:0] ST_DLT  = 4'd2;
    localparam logic [3:0] ST_MI   = 4'd3;
    localparam logic [3:0] ST_MDT  = 4'd4;
    localparam logic [3:0] ST_CAND = 4'd5;
    localparam logic [3:0] ST_MFF  = 4'd6;
    localparam logic [3:0] ST_MP   = 4'd7;
    localparam logic [3:0] ST_SUM1 = 4'd8;
    localparam logic [3:0] ST_SUM2 = 4'd9;
    localparam logic [3:0] ST_MD   = 4'd10;
    localparam logic [3:0] ST_DINI = 4'd11;
    localparam logic [3:0] ST_DIV  = 4'd12;
    localparam logic [3:0] ST_DSAT = 4'd13;
    localparam logic [3:0] ST_SUBD = 4'd14;
    localparam logic [3:0] ST_FIN  = 4'd15;

    // Configuration registers.
    logic signed [31:0] out_min_reg, out_max_reg;
    logic signed [31:0] gain_ff_reg, gain_p_reg, gain_i_reg, gain_d_reg;

    // Controller state and working registers.
    logic [3:0]         state_reg, state_next;
    logic signed [31:0] integ_reg, last_reg;
    logic signed [31:0] sp_reg, meas_reg, err_reg, delta_reg;
    logic [31:0]        dt_reg;
    logic signed [31:0] tmp_reg, acc_reg, cand_reg, dq_reg;
    logic [31:0]        rem_reg;
    logic [DW-1:0]      dvd_reg;
    logic [CW-1:0]      cnt_reg;
    logic               neg_reg;
    logic               out_valid_reg, out_lim_reg;
    logic signed [31:0] out_drive_reg;

    logic               in_acc;
    logic signed [31:0] in_target, in_sample, sp_clamp;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p, mul_sh;
    logic signed [31:0] mul_q;
    logic signed [31:0] add_a, add_b, add_q;
    logic               add_sub;
    logic signed [32:0] add_s;
    logic [32:0]        rem_sh;
    logic               div_ge;
    logic               d_on;
    logic               out_load;
    logic [31:0]        num_mag;

    assign in_acc    = s_tvalid && s_tready;
    assign in_target = s_tdata[31:0];
    assign in_sample = s_tdata[63:32];
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_drive_reg;
    assign m_tuser   = out_lim_reg;
    assign d_on      = (gain_d_reg != 32'sd0) && (dt_reg != 32'd0);
    assign out_load  = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);

    // Target clamp, upper limit tested first.
    always_comb
    begin
        if (in_target > out_max_reg)
        begin
            sp_clamp = out_max_reg;
        end
        else if (in_target < out_min_reg)
        begin
            sp_clamp = out_min_reg;
        end
        else
        begin
            sp_clamp = in_target;
        end
    end

    // Shared multiplier operand select.
    always_comb
    begin
        case (state_reg)
            ST_MI:
            begin
                mul_a = {gain_i_reg[31], gain_i_reg};
                mul_b = {err_reg[31], err_reg};
            end
            ST_MDT:
            begin
                mul_a = {tmp_reg[31], tmp_reg};
                mul_b = {1'b0, dt_reg};
            end
            ST_MFF:
            begin
                mul_a = {gain_ff_reg[31], gain_ff_reg};
                mul_b = {sp_reg[31], sp_reg};
            end
            ST_MP:
            begin
                mul_a = {gain_p_reg[31], gain_p_reg};
                mul_b = {err_reg[31], err_reg};
            end
            default:
            begin
                mul_a = {gain_d_reg[31], gain_d_reg};
                mul_b = {delta_reg[31], delta_reg};
            end
        endcase
    end

    // Product, floor shift and saturation to 32 bits.
    always_comb
    begin
        mul_p  = mul_a * mul_b;
        mul_sh = mul_p >>> FRAC_BITS;
        if (mul_sh > 66'(SAT_MAX_L))
        begin
            mul_q = pidff_pkg::SAT_MAX;
        end
        else if (mul_sh < 66'(SAT_MIN_L))
        begin
            mul_q = pidff_pkg::SAT_MIN;
        end
        else
        begin
            mul_q = mul_sh[31:0];
        end
    end

    // Shared saturating adder operand select.
    always_comb
    begin
        add_sub = 1'b0;
        case (state_reg)
            ST_ERR:
            begin
                add_a   = sp_reg;
                add_b   = meas_reg;
                add_sub = 1'b1;
            end
            ST_DLT:
            begin
                add_a   = meas_reg;
                add_b   = last_reg;
                add_sub = 1'b1;
            end
            ST_CAND:
            begin
                add_a = integ_reg;
                add_b = tmp_reg;
            end
            ST_SUM1:
            begin
                add_a = acc_reg;
                add_b = tmp_reg;
            end
            ST_SUM2:
            begin
                add_a = acc_reg;
                add_b = cand_reg;
            end
            default:
            begin
                add_a   = acc_reg;
                add_b   = dq_reg;
                add_sub = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (add_sub)
        begin
            add_s = {add_a[31], add_a} - {add_b[31], add_b};
        end
        else
        begin
            add_s = {add_a[31], add_a} + {add_b[31], add_b};
        end
        if (add_s[32] != add_s[31])
        begin
            add_q = add_s[32] ? pidff_pkg::SAT_MIN : pidff_pkg::SAT_MAX;
        end
        else
        begin
            add_q = add_s[31:0];
        end
    end

    // Restoring divider step.
    assign rem_sh  = {rem_reg, dvd_reg[DW-1]};
    assign div_ge  = (rem_sh >= {1'b0, dt_reg});
    assign num_mag = tmp_reg[31] ? 32'(-{tmp_reg[31], tmp_reg}) : tmp_reg;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (s_tuser == pidff_pkg::ACT_STEP))
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:  state_next = ST_DLT;
            ST_DLT:  state_next = ST_MI;
            ST_MI:   state_next = ST_MDT;
            ST_MDT:  state_next = ST_CAND;
            ST_CAND: state_next = ST_MFF;
            ST_MFF:  state_next = ST_MP;
            ST_MP:   state_next = ST_SUM1;
            ST_SUM1: state_next = ST_SUM2;
            ST_SUM2: state_next = d_on ? ST_MD : ST_FIN;
            ST_MD:   state_next = ST_DINI;
            ST_DINI: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_DSAT;
                end
            end
            ST_DSAT: state_next = ST_SUBD;
            ST_SUBD: state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_min_reg   <= pidff_pkg::OUT_MIN_RST;
            out_max_reg   <= pidff_pkg::OUT_MAX_RST;
            gain_ff_reg   <= '0;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            integ_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    pidff_pkg::REG_OUT_MIN: out_min_reg <= cfg_data;
                    pidff_pkg::REG_OUT_MAX: out_max_reg <= cfg_data;
                    pidff_pkg::REG_GAIN_FF: gain_ff_reg <= cfg_data;
                    pidff_pkg::REG_GAIN_P:  gain_p_reg  <= cfg_data;
                    pidff_pkg::REG_GAIN_I:  gain_i_reg  <= cfg_data;
                    pidff_pkg::REG_GAIN_D:  gain_d_reg  <= cfg_data;
                    default: ;
                endcase
            end
            // A clear item resets the history at once.
            if (in_acc && (s_tuser == pidff_pkg::ACT_CLEAR))
            begin
                integ_reg <= '0;
                last_reg  <= in_sample;
            end
            // Finish: store the sample and commit the integral only when no clamp happened.
            if (out_load)
            begin
                last_reg <= meas_reg;
                if ((acc_reg <= out_max_reg) && (acc_reg >= out_min_reg))
                begin
                    integ_reg <= cand_reg;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DINI)
            begin
                cnt_reg <= CW'(DW);
            end
            else if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            sp_reg   <= sp_clamp;
            meas_reg <= in_sample;
            dt_reg   <= s_tdata[95:64];
        end
        case (state_reg)
            ST_ERR:  err_reg   <= add_q;
            ST_DLT:  delta_reg <= add_q;
            ST_MI:   tmp_reg   <= mul_q;
            ST_MDT:  tmp_reg   <= mul_q;
            ST_CAND: cand_reg  <= add_q;
            ST_MFF:  tmp_reg   <= mul_q;
            ST_MP:
            begin
                acc_reg <= tmp_reg;
                tmp_reg <= mul_q;
            end
            ST_SUM1: acc_reg   <= add_q;
            ST_SUM2: acc_reg   <= add_q;
            ST_MD:   tmp_reg   <= mul_q;
            ST_DINI:
            begin
                neg_reg <= tmp_reg[31];
                rem_reg <= '0;
                dvd_reg <= {num_mag, FRAC_BITS'(0)};
            end
            ST_DIV:
            begin
                rem_reg <= div_ge ? 32'(rem_sh - {1'b0, dt_reg}) : rem_sh[31:0];
                dvd_reg <= {dvd_reg[DW-2:0], div_ge};
            end
            ST_DSAT:
            begin
                // Saturate the signed quotient to 32 bits.
                if (neg_reg)
                begin
                    if ((|dvd_reg[DW-1:32]) || (dvd_reg[31] && (|dvd_reg[30:0])))
                    begin
                        dq_reg <= pidff_pkg::SAT_MIN;
                    end
                    else
                    begin
                        dq_reg <= 32'(-dvd_reg[31:0]);
                    end
                end
                else if (|dvd_reg[DW-1:31])
                begin
                    dq_reg <= pidff_pkg::SAT_MAX;
                end
                else
                begin
                    dq_reg <= dvd_reg[31:0];
                end
            end
            ST_SUBD: acc_reg <= add_q;
            default: ;
        endcase
        // Output clamp, upper limit tested first.
        if (out_load)
        begin
            if (acc_reg > out_max_reg)
            begin
                out_drive_reg <= out_max_reg;
                out_lim_reg   <= 1'b1;
            end
            else if (acc_reg < out_min_reg)
            begin
                out_drive_reg <= out_min_reg;
                out_lim_reg   <= 1'b1;
            end
            else
            begin
                out_drive_reg <= acc_reg;
                out_lim_reg   <= 1'b0;
            end
        end
    end

    // A clear item leaves the block idle with the integral at zero.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (s_tuser == pidff_pkg::ACT_CLEAR))
        |=> (integ_reg == 32'sd0) && (state_reg == ST_IDLE))
        else $error("clear item did not reset the integral");

    // The divider count is never zero inside the divide state.
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg != '0))
        else $error("divider ran with an empty count");

    // A limited result sits on one of the limits when no configuration write comes with the load.
    a_limited: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !cfg_wr_en) |=> (!m_tuser
        || (m_tdata == out_max_reg) || (m_tdata == out_min_reg)))
        else $error("limited result is not on a limit");

    // A result is loaded only while no earlier result is pending.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("result register overrun");

endmodule
